/* hw/rtl/bnia_pkg.sv */
// ----------------------------------------------------------------------------
// bnia_pkg: shared types and constants of the batch normalization block
// Beat formats of both channels, the queue entry format and state encodings.
// ----------------------------------------------------------------------------
package bnia_pkg;

	localparam int QDEPTH   = 4;
	localparam int QPTR_W   = 2;
	localparam int QCNT_W   = 3;
	localparam int CHEXT_W  = 13;
	localparam logic [31:0] EPS_LSB = 32'd168;
	localparam logic [9:0]  CIU_RESET = 10'd512;

	localparam logic KIND_LOAD   = 1'b0;
	localparam logic KIND_SAMPLE = 1'b1;

	localparam logic REG_CIU = 1'b0;

	typedef struct packed {
		logic               kind;
		logic [8:0]         channel;
		logic signed [31:0] sample;
		logic signed [31:0] gamma;
		logic signed [31:0] beta;
		logic signed [31:0] mean;
		logic [30:0]        variance;
	} in_beat_t;

	typedef struct packed {
		logic signed [31:0] result;
		logic               bad_channel;
	} out_beat_t;

	typedef struct packed {
		logic               kind;
		logic               bad;
		logic [8:0]         channel;
		logic signed [31:0] sample;
		logic signed [31:0] gamma;
		logic signed [31:0] beta;
		logic signed [31:0] mean;
		logic [30:0]        variance;
	} job_t;

	typedef enum logic [2:0] {
		BK_IDLE, BK_READ, BK_MUL, BK_OUT, BK_SOLVE, BK_OMUL, BK_OSTORE
	} back_state_t;

	typedef enum logic [1:0] {
		SV_IDLE, SV_ROOT, SV_DIV
	} solver_state_t;

endpackage

/* hw/rtl/bnia_front.sv */
// ----------------------------------------------------------------------------
// bnia_front: intake and classification
// Checks each beat's channel against the limit, drops bad loads and queues
// the rest for the back end.
// ----------------------------------------------------------------------------
module bnia_front import bnia_pkg::*; #(
	parameter int CHANNELS_MAX = 512
) (
	input  logic     clk,
	input  logic     arst_n,
	input  logic [9:0] channels_in_use,
	input  logic     in_valid,
	output logic     in_stall,
	input  in_beat_t in_data,
	output logic     q_valid,
	output job_t     q_data,
	input  logic     q_pop
);

	localparam logic [CHEXT_W-1:0] CH_MAX = CHEXT_W'(CHANNELS_MAX);

	job_t              fifo_q [QDEPTH];
	logic [QPTR_W-1:0] wr_ptr_q, rd_ptr_q;
	logic [QCNT_W-1:0] count_q;
	logic [CHEXT_W-1:0] limit, ch_ext;
	logic              bad, accept, push;
	job_t              entry;

	always_comb begin
		ch_ext = CHEXT_W'(in_data.channel);
		limit  = (CHEXT_W'(channels_in_use) < CH_MAX) ? CHEXT_W'(channels_in_use) : CH_MAX;
		bad    = !(ch_ext < limit);
		entry.kind     = in_data.kind;
		entry.bad      = bad;
		entry.channel  = in_data.channel;
		entry.sample   = in_data.sample;
		entry.gamma    = in_data.gamma;
		entry.beta     = in_data.beta;
		entry.mean     = in_data.mean;
		entry.variance = in_data.variance;
	end

	assign in_stall = (count_q == QCNT_W'(QDEPTH));
	assign accept   = in_valid && !in_stall;
	// A load on a channel out of range is swallowed here.
	assign push     = accept && !(in_data.kind == KIND_LOAD && bad);
	assign q_valid  = (count_q != '0);
	assign q_data   = fifo_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) fifo_q[wr_ptr_q] <= entry;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) wr_ptr_q <= wr_ptr_q + 1'b1;
			if (q_pop) rd_ptr_q <= rd_ptr_q + 1'b1;
			if (push && !q_pop) count_q <= count_q + 1'b1;
			else if (!push && q_pop) count_q <= count_q - 1'b1;
		end
	end

endmodule

/* hw/rtl/bnia_solver.sv */
// ----------------------------------------------------------------------------
// bnia_solver: scale = gamma / sqrt(variance + eps)
// A bit-pair square root (32 steps) then a restoring divider (60 steps).
// ----------------------------------------------------------------------------
module bnia_solver import bnia_pkg::*; (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               start,
	input  logic signed [31:0] gamma,
	input  logic [30:0]        variance,
	output logic               done,
	output logic signed [31:0] scale
);

	solver_state_t state_q, state_d;
	logic [63:0] rad_q;
	logic [31:0] rem_q, root_q, mag_q;
	logic [59:0] div_q;
	logic [5:0]  cnt_q;
	logic        neg_q, done_q;
	logic signed [31:0] scale_q;

	logic [33:0] remn, trial;
	logic [31:0] root_nx, rem_nx;
	logic [32:0] dremn;
	logic        qbit;
	logic [59:0] quot;
	logic [31:0] sat_val;

	always_comb begin
		remn  = {rem_q, rad_q[63:62]};
		trial = {root_q, 2'b01};
		if (remn >= trial) begin
			rem_nx  = 32'(remn - trial);
			root_nx = {root_q[30:0], 1'b1};
		end else begin
			rem_nx  = remn[31:0];
			root_nx = {root_q[30:0], 1'b0};
		end
		dremn = {rem_q, div_q[59]};
		qbit  = (dremn >= {1'b0, root_q});
		quot  = {div_q[58:0], qbit};
		if (!neg_q) begin
			sat_val = (quot[59:31] != '0) ? 32'h7FFF_FFFF : quot[31:0];
		end else begin
			sat_val = (quot[59:32] != '0 || (quot[31] && quot[30:0] != '0))
				? 32'h8000_0000 : 32'(-quot[31:0]);
		end
	end

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			SV_IDLE: if (start) state_d = SV_ROOT;
			SV_ROOT: if (cnt_q == '0) state_d = SV_DIV;
			SV_DIV:  if (cnt_q == '0) state_d = SV_IDLE;
			default: state_d = SV_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= SV_IDLE;
			done_q  <= 1'b0;
		end else begin
			state_q <= state_d;
			done_q  <= (state_q == SV_DIV) && (cnt_q == '0);
		end
	end

	// The root remainder register is reused as the divider remainder.
	always_ff @(posedge clk) begin
		unique case (state_q)
			SV_IDLE: if (start) begin
				rad_q  <= {32'(variance) + EPS_LSB, 32'd0};
				rem_q  <= '0;
				root_q <= '0;
				cnt_q  <= 6'd31;
				neg_q  <= gamma[31];
				mag_q  <= gamma[31] ? 32'(-gamma) : 32'(gamma);
			end
			SV_ROOT: begin
				rad_q  <= {rad_q[61:0], 2'b00};
				root_q <= root_nx;
				if (cnt_q == '0) begin
					div_q <= {mag_q, 28'd0} + 60'(root_nx[31:1]);
					rem_q <= '0;
					cnt_q <= 6'd59;
				end else begin
					rem_q <= rem_nx;
					cnt_q <= cnt_q - 1'b1;
				end
			end
			SV_DIV: begin
				rem_q <= qbit ? 32'(dremn - {1'b0, root_q}) : dremn[31:0];
				div_q <= quot;
				cnt_q <= cnt_q - 1'b1;
				if (cnt_q == '0) scale_q <= $signed(sat_val);
			end
			default: ;
		endcase
	end

	assign done  = done_q;
	assign scale = scale_q;

endmodule

/* hw/rtl/bnia_back.sv */
// ----------------------------------------------------------------------------
// bnia_back: execution of queued items
// Holds the scale and offset tables, runs loads through the solver and
// good samples through a multiply and round stage into the output register.
// ----------------------------------------------------------------------------
module bnia_back import bnia_pkg::*; #(
	parameter int CHANNELS_MAX = 512
) (
	input  logic      clk,
	input  logic      arst_n,
	input  logic      q_valid,
	input  job_t      q_data,
	output logic      q_pop,
	output logic      out_valid,
	input  logic      out_stall,
	output out_beat_t out_data
);

	localparam int AW = (CHANNELS_MAX > 1) ? $clog2(CHANNELS_MAX) : 1;

	function automatic logic signed [31:0] sat32(input logic signed [63:0] v);
		if (v > 64'sd2147483647) return 32'sh7FFF_FFFF;
		if (v < -64'sd2147483648) return 32'sh8000_0000;
		return v[31:0];
	endfunction

	back_state_t state_q, state_d;
	job_t        job_q;
	logic signed [31:0] scale_mem [CHANNELS_MAX];
	logic signed [31:0] offset_mem [CHANNELS_MAX];
	logic signed [31:0] scale_rd_q, offset_rd_q, scale_q;
	logic signed [63:0] prod_s1;
	logic        out_valid_q;
	out_beat_t   out_q;
	logic [AW-1:0] idx;
	logic        solve_done, out_free;
	logic signed [31:0] solve_scale;
	logic signed [63:0] rounded, y;

	assign idx      = AW'(CHEXT_W'(job_q.channel));
	assign out_free = !out_valid_q || !out_stall;
	assign q_pop    = (state_q == BK_IDLE) && q_valid;

	bnia_solver u_solver (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (q_pop && q_data.kind == KIND_LOAD),
		.gamma    (q_data.gamma),
		.variance (q_data.variance),
		.done     (solve_done),
		.scale    (solve_scale)
	);

	// Rounding half up by 2^24 is an arithmetic shift after adding 2^23.
	always_comb begin
		rounded = (prod_s1 + 64'sd8388608) >>> 24;
		y       = rounded + 64'(offset_rd_q);
	end

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			BK_IDLE: if (q_valid) begin
				if (q_data.kind == KIND_LOAD) state_d = BK_SOLVE;
				else if (q_data.bad) state_d = BK_OUT;
				else state_d = BK_READ;
			end
			BK_READ:   state_d = BK_MUL;
			BK_MUL:    state_d = BK_OUT;
			BK_OUT:    if (out_free) state_d = BK_IDLE;
			BK_SOLVE:  if (solve_done) state_d = BK_OMUL;
			BK_OMUL:   state_d = BK_OSTORE;
			BK_OSTORE: state_d = BK_IDLE;
			default:   state_d = BK_IDLE;
		endcase
	end

	always_ff @(posedge clk) begin
		if (state_q == BK_OSTORE) begin
			scale_mem[idx]  <= scale_q;
			offset_mem[idx] <= sat32(64'(job_q.beta) - rounded);
		end
		if (state_q == BK_READ) begin
			scale_rd_q  <= scale_mem[idx];
			offset_rd_q <= offset_mem[idx];
		end
	end

	always_ff @(posedge clk) begin
		if (q_pop) job_q <= q_data;
		if (state_q == BK_MUL) prod_s1 <= 64'(job_q.sample) * 64'(scale_rd_q);
		if (state_q == BK_SOLVE && solve_done) scale_q <= solve_scale;
		if (state_q == BK_OMUL) prod_s1 <= 64'(job_q.mean) * 64'(scale_q);
		if (state_q == BK_OUT && out_free) begin
			out_q.result      <= job_q.bad ? 32'sd0 : sat32(y);
			out_q.bad_channel <= job_q.bad;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= BK_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (state_q == BK_OUT && out_free) out_valid_q <= 1'b1;
			else if (!out_stall) out_valid_q <= 1'b0;
		end
	end

	assign out_valid = out_valid_q;
	assign out_data  = out_q;

endmodule

/* hw/rtl/batchnorm_inference_affine.sv */
// ----------------------------------------------------------------------------
// batchnorm_inference_affine: per-channel batch normalization, Q8.24
// Stores per-channel scale and offset from load beats and normalizes samples.
// ----------------------------------------------------------------------------
// The input channel carries two kinds of beat. A load beat brings gamma, beta,
// mean and variance for one channel; the block derives the scale and offset
// and stores them, and returns no beat. A sample beat brings a channel and an
// activation and returns one output beat with the normalized, saturated value.
// Samples on a channel at or above channels_in_use come back as zero with
// bad_channel set; loads on such a channel are dropped.
// Beats are taken whenever in_valid is high and in_stall is low. The front end
// puts them into a four-entry queue, so in_stall rises only when it is full.
// The back end works on one item at a time. A good sample passes from the
// queue head through table read, multiply and round into the output register.
// A load runs through the square root (32 steps) and the restoring divider
// (60 steps), which reuse the remainder and counter registers.
// A beat waiting in the output register while out_stall is high holds the
// back end; the queue keeps accepting until it fills.
// Reset empties the queue and the output register and sets channels_in_use
// to 512. The tables are not cleared and must be loaded before use.
// ----------------------------------------------------------------------------
module batchnorm_inference_affine import bnia_pkg::*; #(
	parameter int CHANNELS_MAX = 512
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [2:0]  paddr,
	input  logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic        pready,
	input  logic        in_valid,
	output logic        in_stall,
	input  in_beat_t    in_data,
	output logic        out_valid,
	input  logic        out_stall,
	output out_beat_t   out_data
);

	logic [9:0] ciu_q;
	logic       q_valid, q_pop;
	job_t       q_data;

	// Register index is the word address; only index zero exists.
	assign pready = 1'b1;
	assign prdata = (paddr[2] == REG_CIU) ? 32'(ciu_q) : 32'd0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ciu_q <= CIU_RESET;
		end else if (psel && penable && pwrite && paddr[2] == REG_CIU) begin
			ciu_q <= pwdata[9:0];
		end
	end

	bnia_front #(.CHANNELS_MAX(CHANNELS_MAX)) u_front (
		.clk             (clk),
		.arst_n          (arst_n),
		.channels_in_use (ciu_q),
		.in_valid        (in_valid),
		.in_stall        (in_stall),
		.in_data         (in_data),
		.q_valid         (q_valid),
		.q_data          (q_data),
		.q_pop           (q_pop)
	);

	bnia_back #(.CHANNELS_MAX(CHANNELS_MAX)) u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.q_valid   (q_valid),
		.q_data    (q_data),
		.q_pop     (q_pop),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.out_data  (out_data)
	);

endmodule

/* hw/rtl/bnia_checker.sv */
// ----------------------------------------------------------------------------
// bnia_checker: port-level checks of the batch normalization block
// Watches the top-level ports only and is bound to the top level.
// ----------------------------------------------------------------------------
module bnia_checker import bnia_pkg::*; (
	input logic      clk,
	input logic      arst_n,
	input logic      pready,
	input logic      in_stall,
	input logic      out_valid,
	input logic      out_stall,
	input out_beat_t out_data
);

	// A beat held by the receiver stays put.
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid && $stable(out_data))
		else $error("output beat changed while stalled");

	// A flagged sample always carries a zero result.
	a_bad_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_data.bad_channel |-> out_data.result == 32'sd0)
		else $error("bad channel beat with nonzero result");

	// The queue is empty right after reset, so intake is open.
	a_reset_open: assert property (@(posedge clk)
		!arst_n |=> !in_stall)
		else $error("input stalled right after reset");

	a_pready: assert property (@(posedge clk) disable iff (!arst_n) pready)
		else $error("pready dropped");

endmodule

bind batchnorm_inference_affine bnia_checker u_bnia_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.pready    (pready),
	.in_stall  (in_stall),
	.out_valid (out_valid),
	.out_stall (out_stall),
	.out_data  (out_data)
);
